// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file ctd_checker.sv.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ctd_pkg.sv =====
// Package for the chunked transfer decoder: result type, character codes
// and character classification helpers. No dependencies.
package ctd_pkg;

	localparam int SIZE_BITS_DEF = 32;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       data_valid;
		logic       done_res;
		logic       error;
	} ctd_res_t;

	// bit 4: character is a hex digit, bits 3:0: its value
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

// ===== hdl/ctd_in_if.sv =====
// Input request channel of the chunked transfer decoder: one raw body byte.
// No dependencies.
interface ctd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

// ===== hdl/ctd_res_if.sv =====
// Result channel of the chunked transfer decoder: decoded byte and flags.
// No dependencies.
interface ctd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       data_valid;
	logic       done_res;
	logic       error;

	modport source(output valid, output out_byte, output data_valid, output done_res,
		output error, input ready);
	modport sink(input valid, input out_byte, input data_valid, input done_res,
		input error, output ready);
endinterface

// ===== hdl/ctd_core.sv =====
// Decoder state and next-state logic: size line parse, payload count, CR LF checks.
// Depends on ctd_pkg.
module ctd_core #(
	parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	output ctd_pkg::ctd_res_t res
);
	import ctd_pkg::*;

	typedef enum logic [2:0] {
		PH_SIZE = 3'd0,
		PH_DATA = 3'd1,
		PH_FOOT = 3'd2,
		PH_LAST = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		LP_START  = 3'd0,
		LP_ZERO   = 3'd1,
		LP_PREFIX = 3'd2,
		LP_DIGITS = 3'd3,
		LP_TAIL   = 3'd4
	} prog_t;

	phase_t               phase_q, phase_n;
	prog_t                prog_q, prog_n;
	logic [SIZE_BITS-1:0] rem_q, rem_n, rem_dec;
	logic                 seen_q, seen_n;
	logic                 cr_q, cr_n;
	logic                 err_q, err_n;
	logic [4:0]           hv;
	logic                 do_add;
	logic                 ovf;
	logic [7:0]           data;
	logic                 valid;

	assign hv      = hex_value(in_byte);
	assign ovf     = rem_q[SIZE_BITS-1 -: 4] != 4'd0;
	assign rem_dec = rem_q - SIZE_BITS'(1);

	always_comb begin
		phase_n = phase_q;
		prog_n  = prog_q;
		rem_n   = rem_q;
		seen_n  = seen_q;
		cr_n    = cr_q;
		err_n   = err_q;
		do_add  = 1'b0;
		data    = 8'd0;
		valid   = 1'b0;
		if (!err_q) begin
			unique case (phase_q)
				PH_SIZE: begin
					if (in_byte == CH_LF && cr_q) begin
						cr_n = 1'b0;
						if (!seen_q) begin
							err_n = 1'b1;
						end else begin
							phase_n = (rem_q == '0) ? PH_LAST : PH_DATA;
							prog_n  = LP_START;
							seen_n  = 1'b0;
						end
					end else begin
						cr_n = (in_byte == CH_CR);
						unique case (prog_q)
							LP_START: begin
								if (is_blank(in_byte)) begin
									prog_n = LP_START;
								end else if (in_byte == CH_ZERO) begin
									seen_n = 1'b1;
									prog_n = LP_ZERO;
								end else if (hv[4]) begin
									seen_n = 1'b1;
									do_add = 1'b1;
									prog_n = LP_DIGITS;
								end else begin
									prog_n = LP_TAIL;
								end
							end
							LP_ZERO: begin
								if (in_byte == CH_LO_X || in_byte == CH_UP_X) begin
									prog_n = LP_PREFIX;
								end else if (hv[4]) begin
									do_add = 1'b1;
									prog_n = LP_DIGITS;
								end else begin
									prog_n = LP_TAIL;
								end
							end
							LP_PREFIX, LP_DIGITS: begin
								if (hv[4]) begin
									do_add = 1'b1;
									prog_n = LP_DIGITS;
								end else begin
									prog_n = LP_TAIL;
								end
							end
							default: prog_n = LP_TAIL;
						endcase
					end
				end
				PH_DATA: begin
					data  = in_byte;
					valid = 1'b1;
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						phase_n = PH_FOOT;
						cr_n    = 1'b0;
					end
				end
				PH_FOOT, PH_LAST: begin
					if (!cr_q) begin
						if (in_byte == CH_CR) cr_n = 1'b1;
						else err_n = 1'b1;
					end else begin
						cr_n = 1'b0;
						if (in_byte == CH_LF) phase_n = (phase_q == PH_FOOT) ? PH_SIZE : PH_DONE;
						else err_n = 1'b1;
					end
				end
				default: phase_n = phase_q;
			endcase
			if (do_add) begin
				if (ovf) err_n = 1'b1;
				else rem_n = {rem_q[SIZE_BITS-5:0], hv[3:0]};
			end
		end
	end

	assign res.out_byte   = data;
	assign res.data_valid = valid;
	assign res.done_res   = !err_n && (phase_n == PH_DONE);
	assign res.error      = err_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			prog_q  <= LP_START;
			rem_q   <= '0;
			seen_q  <= 1'b0;
			cr_q    <= 1'b0;
			err_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			prog_q  <= prog_n;
			rem_q   <= rem_n;
			seen_q  <= seen_n;
			cr_q    <= cr_n;
			err_q   <= err_n;
		end
	end

endmodule

// ===== hdl/chunked_transfer_decoder_top.sv =====
// Chunked transfer decoder top: request handshake and result register.
// Depends on ctd_pkg, ctd_in_if, ctd_res_if and ctd_core.
// The result of a byte is registered and shown in the cycle after the byte is taken.
// Throughput: one byte per cycle unless out_ch.ready holds a full result register.
// A new byte is taken whenever the result register is empty or being drained.
// Reset (arst_n low) returns to the start of a size line with no error and no result.
module chunked_transfer_decoder_top #(
	parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ctd_in_if.sink    in_ch,
	ctd_res_if.source out_ch
);
	import ctd_pkg::*;

	ctd_res_t res;
	ctd_res_t res_s1;
	logic     vld_s1;
	logic     take;

	assign in_ch.ready = !vld_s1 || out_ch.ready;
	assign take        = in_ch.valid && in_ch.ready;

	ctd_core #(
		.SIZE_BITS(SIZE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.in_byte(in_ch.in_byte),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_s1 <= res;
	end

	assign out_ch.valid      = vld_s1;
	assign out_ch.out_byte   = res_s1.out_byte;
	assign out_ch.data_valid = res_s1.data_valid;
	assign out_ch.done_res   = res_s1.done_res;
	assign out_ch.error      = res_s1.error;

endmodule

// ===== hdl/ctd_checker.sv =====
// Port-level checks for the chunked transfer decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ctd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       data_valid,
	input logic       done_res,
	input logic       error
);
	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && error) begin
			err_seen_q <= 1'b1;
		end
	end

	`CTD_ASSERT_NOW(a_err_sticky, out_valid && err_seen_q, error, "error flag dropped")
	`CTD_ASSERT_NOW(a_idle_byte_zero, out_valid && !data_valid, out_byte == 8'd0,
		"non-payload result carries a byte")
	`CTD_ASSERT_NOW(a_err_quiet, out_valid && error, !data_valid && !done_res,
		"result active while in error")
	`CTD_ASSERT_NEXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(error), "stalled result changed")

endmodule

bind chunked_transfer_decoder_top ctd_checker u_ctd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.data_valid(out_ch.data_valid),
	.done_res  (out_ch.done_res),
	.error     (out_ch.error)
);
